// ----- hw/rtl/mrnp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrnp_pkg
// Shared types, constants and the character classifier for the
// multi-radix number parser.
// ----------------------------------------------------------------------------
package mrnp_pkg;

  localparam int unsigned MAX_STRING_LEN = 256;
  // position counter holds 0..MAX_STRING_LEN
  localparam int unsigned POS_W = $clog2(MAX_STRING_LEN + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONUM = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  localparam logic [31:0] DEC_LIMIT = 32'd429496729;
  localparam logic [31:0] HEX_MASK  = 32'hf000_0000;
  localparam logic [31:0] OCT_MASK  = 32'he000_0000;
  localparam logic [31:0] BIN_MASK  = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       string_start;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [7:0]  stop_index;
  } out_t;

  typedef struct packed {
    logic       is_nul;
    logic       is_space;   // 0x01..0x20
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       is_dec;
    logic       is_nzdec;   // 1..9
    logic       is_oct;
    logic       is_bin;
    logic       is_hex;
    logic [3:0] digit;
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic             start;
    logic             last;
    logic [POS_W-1:0] idx;
  } item_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r          = '0;
    r.is_nul   = (c == 8'h00);
    r.is_space = (c != 8'h00) && (c <= 8'h20);
    r.is_zero  = (c == 8'h30);
    r.is_x     = (c == 8'h78) || (c == 8'h58);
    r.is_b     = (c == 8'h62) || (c == 8'h42);
    r.is_dec   = (c >= 8'h30) && (c <= 8'h39);
    r.is_nzdec = (c >= 8'h31) && (c <= 8'h39);
    r.is_oct   = (c >= 8'h30) && (c <= 8'h37);
    r.is_bin   = (c == 8'h30) || (c == 8'h31);
    if (r.is_dec) begin
      r.is_hex = 1'b1;
      r.digit  = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.is_hex = 1'b1;
      r.digit  = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/multi_radix_number_parser.sv -----
// ----------------------------------------------------------------------------
// multi_radix_number_parser
// Streams a string byte by byte and parses one unsigned 32-bit number
// (hex 0x, octal 0, binary b, or decimal) with status and stop index.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in_     | input     | in_valid/in_ready   | char_byte, string_start, end
//   out_    | output    | out_valid/out_ready | value, status, stop_index
//
// One character per cycle while no result is held by out_ready low; the byte that
// ends the number reaches the output through a queue entry, then the output register.
// The two-entry queue lets the classifier keep accepting while a result waits.
// A result held by out_ready low stalls the parser; the queue fills and then
// drops in_ready.
// rst_n is synchronous: parser returns to skipping spaces, position to zero.
// ----------------------------------------------------------------------------
module multi_radix_number_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrnp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mrnp_pkg::out_t out_data
);
  import mrnp_pkg::*;

  logic  push, pop, q_full, q_not_empty;
  item_t push_item, head;

  mrnp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  mrnp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  mrnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (q_not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/mrnp_front.sv -----
// ----------------------------------------------------------------------------
// mrnp_front
// Accepts characters, tracks the string position and classifies each byte.
// ----------------------------------------------------------------------------
module mrnp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mrnp_pkg::in_t        in_data,
  output logic                 push,
  output mrnp_pkg::item_t      push_item,
  input  logic                 q_full
);
  import mrnp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] idx;
  logic             over;
  logic [7:0]       c_eff;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    idx   = in_data.string_start ? '0 : pos_r;
    over  = (32'(idx) >= MAX_STRING_LEN);
    // bytes past the maximum length read as terminator
    c_eff = over ? 8'h00 : in_data.char_byte;
    pos_nxt = over ? idx : idx + POS_W'(1);
    push_item.cls   = classify(c_eff);
    push_item.start = in_data.string_start;
    push_item.last  = in_data.string_end;
    push_item.idx   = idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- hw/rtl/mrnp_fifo.sv -----
// ----------------------------------------------------------------------------
// mrnp_fifo
// Two-entry queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module mrnp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrnp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output mrnp_pkg::item_t head
);
  import mrnp_pkg::*;

  item_t      mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

// ----- hw/rtl/mrnp_back.sv -----
// ----------------------------------------------------------------------------
// mrnp_back
// Radix state machine and accumulator; one classified byte per cycle unless a
// held result waits on out_ready; the result is held in an output register.
// ----------------------------------------------------------------------------
module mrnp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            not_empty,
  input  mrnp_pkg::item_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output mrnp_pkg::out_t  out_data
);
  import mrnp_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP, PH_ZERO, PH_HEX_FIRST, PH_HEX, PH_OCT, PH_BIN_FIRST, PH_BIN, PH_DEC
  } phase_t;

  localparam logic [POS_W:0] IDX_ONE = (POS_W + 1)'(1);

  phase_t         phase_r, ph, nph;
  logic [31:0]    acc_r, acc, nacc;
  logic           sent_r, sent, sent_nxt;
  logic           out_valid_r;
  out_t           out_r;
  logic           res;
  logic [31:0]    rval;
  logic [1:0]     rst_code;
  logic [POS_W:0] ridx;
  logic [7:0]     stop_sat;
  cls_t           cl;

  assign pop       = not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    cl       = head.cls;
    ph       = head.start ? PH_SKIP : phase_r;
    acc      = head.start ? 32'd0 : acc_r;
    sent     = head.start ? 1'b0 : sent_r;
    nph      = ph;
    nacc     = acc;
    res      = 1'b0;
    rval     = 32'd0;
    rst_code = ST_OK;
    ridx     = {1'b0, head.idx};
    if (!sent) begin
      unique case (ph)
        PH_SKIP: begin
          if (cl.is_nul) begin
            res = 1'b1; rst_code = ST_NONUM; ridx = '0;
          end else if (cl.is_space) begin
            nph = PH_SKIP;
          end else if (cl.is_zero) begin
            nph = PH_ZERO;
          end else if (cl.is_b) begin
            nph = PH_BIN_FIRST;
          end else if (cl.is_nzdec) begin
            nacc = {28'd0, cl.digit};
            nph  = PH_DEC;
          end else begin
            res = 1'b1; rst_code = ST_NONUM; ridx = '0;
          end
        end
        PH_ZERO: begin
          if (cl.is_x) begin
            nph = PH_HEX_FIRST;
          end else if (cl.is_oct) begin
            nacc = {28'd0, cl.digit};
            nph  = PH_OCT;
          end else begin
            res = 1'b1;
          end
        end
        PH_HEX_FIRST: begin
          if (cl.is_hex) begin
            nacc = {28'd0, cl.digit};
            nph  = PH_HEX;
          end else begin
            res = 1'b1; rst_code = ST_NONUM; ridx = '0;
          end
        end
        PH_HEX: begin
          if (!cl.is_hex) begin
            res = 1'b1; rval = acc;
          end else if ((acc & HEX_MASK) != 32'd0) begin
            res = 1'b1; rst_code = ST_OVF; ridx = '0;
          end else begin
            nacc = {acc[27:0], cl.digit};
          end
        end
        PH_OCT: begin
          if (!cl.is_oct) begin
            res = 1'b1; rval = acc;
          end else if ((acc & OCT_MASK) != 32'd0) begin
            res = 1'b1; rst_code = ST_OVF; ridx = '0;
          end else begin
            nacc = {acc[28:0], cl.digit[2:0]};
          end
        end
        PH_BIN_FIRST: begin
          if (cl.is_bin) begin
            nacc = {31'd0, cl.digit[0]};
            nph  = PH_BIN;
          end else begin
            res = 1'b1; rst_code = ST_NONUM; ridx = '0;
          end
        end
        PH_BIN: begin
          if (!cl.is_bin) begin
            res = 1'b1; rval = acc;
          end else if ((acc & BIN_MASK) != 32'd0) begin
            res = 1'b1; rst_code = ST_OVF; ridx = '0;
          end else begin
            nacc = {acc[30:0], cl.digit[0]};
          end
        end
        PH_DEC: begin
          if (!cl.is_dec) begin
            res = 1'b1; rval = acc;
          end else if (acc > DEC_LIMIT || (acc == DEC_LIMIT && cl.digit > 4'd5)) begin
            res = 1'b1; rst_code = ST_OVF; ridx = '0;
          end else begin
            nacc = {acc[28:0], 3'd0} + {acc[30:0], 1'b0} + {28'd0, cl.digit};
          end
        end
        default: begin
          nph = PH_SKIP;
          res = 1'b1; rst_code = ST_NONUM; ridx = '0;
        end
      endcase
      // implied terminator after the last byte of the string
      if (!res && head.last) begin
        res = 1'b1;
        unique case (nph)
          PH_ZERO: begin
            rval = 32'd0; ridx = {1'b0, head.idx} + IDX_ONE;
          end
          PH_HEX, PH_OCT, PH_BIN, PH_DEC: begin
            rval = nacc; ridx = {1'b0, head.idx} + IDX_ONE;
          end
          default: begin
            rst_code = ST_NONUM; ridx = '0;
          end
        endcase
      end
    end
    sent_nxt = sent || res || head.last;
    stop_sat = (ridx > (POS_W + 1)'(255)) ? 8'hff : ridx[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP;
      acc_r       <= 32'd0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= nph;
        acc_r   <= nacc;
        sent_r  <= sent_nxt;
      end
      if (pop && res) begin
        out_valid_r      <= 1'b1;
        out_r.value      <= rval;
        out_r.status     <= rst_code;
        out_r.stop_index <= stop_sat;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> (out_r.value == 32'd0 && out_r.stop_index == 8'd0))
    else $error("failed result carries nonzero value or index");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res) |=> sent_r)
    else $error("result emitted but string not closed");

endmodule
